// ----- design/closest_point_on_collider_macros.svh -----
// Assertion helpers shared by the collider query blocks.
`ifndef CLOSEST_POINT_ON_COLLIDER_MACROS_SVH
`define CLOSEST_POINT_ON_COLLIDER_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CPOC_CHECK_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every edge out of reset.
`define CPOC_CHECK_HOLDS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- design/cpoc_pkg.sv -----
package cpoc_pkg;

  typedef enum logic [1:0] {
    SHAPE_SPHERE = 2'd0,
    SHAPE_PLANE  = 2'd1,
    SHAPE_BOX    = 2'd2,
    SHAPE_PASS   = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    REG_KIND   = 3'd0,
    REG_RADIUS = 3'd1,
    REG_BOX_X  = 3'd2,
    REG_BOX_Y  = 3'd3,
    REG_BOX_Z  = 3'd4
  } cfg_reg_t;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 18;
  localparam int SIZE_W  = 31;
  localparam int MAG_W   = 31;
  // Plane distance, wide enough for the smallest fraction width in use.
  localparam int DIST_W  = 46;
  localparam int ROOT_STAGES = 32;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] q;
    logic [2:0][COORD_W-1:0] c;
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][NORM_W-1:0]  nrm;
    logic [DIST_W-1:0]       plane_dist;
    logic [2:0]              neg;
  } back_pay_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    back_pay_t             back;
  } root_pay_t;

  function automatic logic [COORD_W-1:0] sat32(input logic signed [65:0] v);
    logic [COORD_W-1:0] res;
    if (v[65:31] == '0 || v[65:31] == '1) begin
      res = v[31:0];
    end else if (v[65]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

// ----- design/cpoc_root.sv -----
`include "closest_point_on_collider_macros.svh"

module cpoc_root (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [63:0]         in_rad,
  input  cpoc_pkg::root_pay_t in_pay,
  output logic                out_valid,
  output logic [31:0]         out_root,
  output cpoc_pkg::root_pay_t out_pay
);

  localparam int STAGES = cpoc_pkg::ROOT_STAGES;

  logic                v_r   [STAGES];
  logic [63:0]         x_r   [STAGES];
  logic [63:0]         r_r   [STAGES];
  cpoc_pkg::root_pay_t pay_r [STAGES];

  // One result bit per stage, from the top pair of radicand bits downwards.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic                v_src;
    logic [63:0]         x_src;
    logic [63:0]         r_src;
    cpoc_pkg::root_pay_t pay_src;
    logic [64:0]         trial;
    logic [63:0]         x_nxt;
    logic [63:0]         r_nxt;

    if (i == 0) begin : g_head
      always_comb begin
        v_src   = in_valid;
        x_src   = in_rad;
        r_src   = '0;
        pay_src = in_pay;
      end
    end else begin : g_tail
      always_comb begin
        v_src   = v_r[i-1];
        x_src   = x_r[i-1];
        r_src   = r_r[i-1];
        pay_src = pay_r[i-1];
      end
    end

    always_comb begin
      trial = {1'b0, r_src} + {1'b0, BIT};
      if ({1'b0, x_src} >= trial) begin
        x_nxt = x_src - trial[63:0];
        r_nxt = (r_src >> 1) + BIT;
      end else begin
        x_nxt = x_src;
        r_nxt = r_src >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]   <= x_nxt;
      r_r[i]   <= r_nxt;
      pay_r[i] <= pay_src;
    end
  end

  logic rem_ok;

  assign out_valid = v_r[STAGES-1];
  assign out_root  = r_r[STAGES-1][31:0];
  assign out_pay   = pay_r[STAGES-1];

  assign rem_ok = x_r[STAGES-1] <= (r_r[STAGES-1] << 1);

  `CPOC_CHECK_IMPLY(a_root_rem, clk, rst_n, out_valid, rem_ok, "root remainder exceeds twice the root")

endmodule

// ----- design/cpoc_div.sv -----
`include "closest_point_on_collider_macros.svh"

module cpoc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [2:0][30:0]         in_mag,
  input  logic [31:0]              in_len,
  input  cpoc_pkg::back_pay_t      in_pay,
  output logic                     out_valid,
  output logic [2:0][FRAC_BITS:0]  out_quo,
  output logic [31:0]              out_len,
  output cpoc_pkg::back_pay_t      out_pay
);

  localparam int STAGES = FRAC_BITS + 1;

  logic                    v_r   [STAGES];
  logic [2:0][32:0]        rem_r [STAGES];
  logic [2:0][FRAC_BITS:0] quo_r [STAGES];
  logic [31:0]             len_r [STAGES];
  cpoc_pkg::back_pay_t     pay_r [STAGES];

  // Restoring division, one quotient bit per stage for all three lanes.
  // The offset never exceeds the length, so the partial remainder stays
  // below the divisor and the quotient is at most one.
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic                    v_src;
    logic [2:0][32:0]        rem_src;
    logic [2:0][FRAC_BITS:0] quo_src;
    logic [31:0]             len_src;
    cpoc_pkg::back_pay_t     pay_src;
    logic [2:0][32:0]        rem_nxt;
    logic [2:0][FRAC_BITS:0] quo_nxt;

    if (j == 0) begin : g_head
      always_comb begin
        v_src = in_valid;
        for (int i = 0; i < 3; i++) begin
          rem_src[i] = 33'(in_mag[i]);
        end
        quo_src = '0;
        len_src = in_len;
        pay_src = in_pay;
      end
    end else begin : g_tail
      always_comb begin
        v_src   = v_r[j-1];
        rem_src = rem_r[j-1];
        quo_src = quo_r[j-1];
        len_src = len_r[j-1];
        pay_src = pay_r[j-1];
      end
    end

    always_comb begin
      logic [32:0] trial;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
        trial = (j == 0) ? rem_src[i] : {rem_src[i][31:0], 1'b0};
        ge    = trial >= {1'b0, len_src};
        rem_nxt[i] = ge ? trial - {1'b0, len_src} : trial;
        quo_nxt[i] = {quo_src[i][FRAC_BITS-1:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      quo_r[j] <= quo_nxt;
      len_r[j] <= len_src;
      pay_r[j] <= pay_src;
    end
  end

  logic quo_ok;

  assign out_valid = v_r[STAGES-1];
  assign out_quo   = quo_r[STAGES-1];
  assign out_len   = len_r[STAGES-1];
  assign out_pay   = pay_r[STAGES-1];

  always_comb begin
    quo_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (out_quo[i][FRAC_BITS] && out_quo[i][FRAC_BITS-1:0] != '0) begin
        quo_ok = 1'b0;
      end
    end
  end

  `CPOC_CHECK_IMPLY(a_quo_bound, clk, rst_n, out_valid && (out_len != '0), quo_ok, "unit offset exceeds one")

endmodule

// ----- design/closest_point_on_collider.sv -----
// Closest point on a collider: sphere, plane or axis-aligned box (or the
// query passed through), signed fixed point with FRAC_BITS fraction bits.
// Input beat: raise start with the query point, collider centre, per-axis
// scale and plane normal on the in_ ports; the beat is taken at a rising
// edge with start high and busy low. busy is high only while rst_n is low,
// so one beat can be taken every cycle.
// Result beat: out_valid is high for exactly one cycle with out_closest_x/y/z.
// Results leave in the order the beats arrived, one result per cycle
// sustained; the default FRAC_BITS of 16 gives Q16.16.
// The path runs through the 32-stage square root and the FRAC_BITS + 1
// stage divider that normalise the sphere offset; every shape takes the same
// path length so that order is kept.
// The receiver cannot hold results back; none is needed, as nothing waits.
// Configuration writes on cfg_we / cfg_index / cfg_wdata take effect at the
// next edge and must be made while no beat is in flight.
// A synchronous reset empties the pipeline and restores the registers: a
// sphere of radius one half and a unit box.
`include "closest_point_on_collider_macros.svh"

module closest_point_on_collider #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  logic signed [31:0] in_query_z,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  input  logic signed [17:0] in_plane_normal_x,
  input  logic signed [17:0] in_plane_normal_y,
  input  logic signed [17:0] in_plane_normal_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_closest_x,
  output logic signed [31:0] out_closest_y,
  output logic signed [31:0] out_closest_z
);

  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int PMW  = FRAC_BITS + 34;
  localparam int MRW  = PMW + 1;
  localparam logic [30:0] RADIUS_RST = 31'(1 << (FRAC_BITS - 1));
  localparam logic [30:0] BOX_RST    = 31'(1 << FRAC_BITS);

  // ---------------- configuration ----------------
  cpoc_pkg::shape_t kind_r;
  logic [30:0]      radius_r;
  logic [2:0][30:0] box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= cpoc_pkg::SHAPE_SPHERE;
      radius_r <= RADIUS_RST;
      box_r    <= {BOX_RST, BOX_RST, BOX_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        cpoc_pkg::REG_KIND:   kind_r   <= cpoc_pkg::shape_t'(cfg_wdata[1:0]);
        cpoc_pkg::REG_RADIUS: radius_r <= cfg_wdata;
        cpoc_pkg::REG_BOX_X:  box_r[0] <= cfg_wdata;
        cpoc_pkg::REG_BOX_Y:  box_r[1] <= cfg_wdata;
        cpoc_pkg::REG_BOX_Z:  box_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = ~rst_n;

  // ---------------- stage a: input register ----------------
  logic                a_v_r;
  cpoc_pkg::back_pay_t a_pay_r;
  cpoc_pkg::back_pay_t a_pay_nxt;

  always_comb begin
    a_pay_nxt.q          = {in_query_z, in_query_y, in_query_x};
    a_pay_nxt.c          = {in_center_z, in_center_y, in_center_x};
    a_pay_nxt.s          = {in_scale_z, in_scale_y, in_scale_x};
    a_pay_nxt.nrm        = {in_plane_normal_z, in_plane_normal_y, in_plane_normal_x};
    a_pay_nxt.plane_dist = '0;
    a_pay_nxt.neg        = '0;
  end

  // ---------------- stage b: offset and magnitude ----------------
  logic                b_v_r;
  cpoc_pkg::back_pay_t b_pay_r, b_pay_nxt;
  logic [2:0][32:0]    b_d_r, b_d_nxt;
  logic [2:0][31:0]    b_mag_r, b_mag_nxt;

  always_comb begin
    logic signed [32:0] diff;
    b_pay_nxt = a_pay_r;
    for (int i = 0; i < 3; i++) begin
      diff = 33'($signed(a_pay_r.q[i])) - 33'($signed(a_pay_r.c[i]));
      b_d_nxt[i]       = diff;
      b_pay_nxt.neg[i] = diff[32];
      b_mag_nxt[i]     = diff[32] ? 32'(-diff) : diff[31:0];
    end
  end

  // ---------------- stage c: range shift, plane products ----------------
  logic                c_v_r;
  cpoc_pkg::back_pay_t c_pay_r;
  logic [2:0][30:0]    c_mag_r, c_mag_nxt;
  logic [2:0][50:0]    c_p_r, c_p_nxt;

  always_comb begin
    logic               big;
    logic signed [50:0] prod;
    big = b_mag_r[0][31] | b_mag_r[1][31] | b_mag_r[2][31];
    for (int i = 0; i < 3; i++) begin
      c_mag_nxt[i] = big ? b_mag_r[i][31:1] : b_mag_r[i][30:0];
      prod         = $signed(b_d_r[i]) * $signed(b_pay_r.nrm[i]);
      c_p_nxt[i]   = prod;
    end
  end

  // ---------------- stage d: squares, plane dot product ----------------
  logic                d_v_r;
  cpoc_pkg::back_pay_t d_pay_r;
  logic [2:0][30:0]    d_mag_r;
  logic [2:0][61:0]    d_sq_r, d_sq_nxt;
  logic [52:0]         d_dot_r, d_dot_nxt;

  always_comb begin
    logic signed [52:0] acc;
    for (int i = 0; i < 3; i++) begin
      d_sq_nxt[i] = 62'(c_mag_r[i]) * 62'(c_mag_r[i]);
    end
    acc = 53'($signed(c_p_r[0])) + 53'($signed(c_p_r[1])) + 53'($signed(c_p_r[2]));
    d_dot_nxt = acc;
  end

  // ---------------- stage e: sum of squares, plane distance ----------------
  logic                e_v_r;
  logic [63:0]         e_sum_r, e_sum_nxt;
  cpoc_pkg::root_pay_t e_pay_r, e_pay_nxt;

  always_comb begin
    logic signed [53:0] rnd;
    logic signed [53:0] shd;
    e_sum_nxt = 64'(d_sq_r[0]) + 64'(d_sq_r[1]) + 64'(d_sq_r[2]);
    rnd = 54'($signed(d_dot_r)) + 54'(HALF);
    shd = rnd >>> FRAC_BITS;
    e_pay_nxt.mag             = d_mag_r;
    e_pay_nxt.back            = d_pay_r;
    e_pay_nxt.back.plane_dist = shd[cpoc_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      a_v_r <= start;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_pay_r <= a_pay_nxt;
    b_pay_r <= b_pay_nxt;
    b_d_r   <= b_d_nxt;
    b_mag_r <= b_mag_nxt;
    c_pay_r <= b_pay_r;
    c_mag_r <= c_mag_nxt;
    c_p_r   <= c_p_nxt;
    d_pay_r <= c_pay_r;
    d_mag_r <= c_mag_r;
    d_sq_r  <= d_sq_nxt;
    d_dot_r <= d_dot_nxt;
    e_sum_r <= e_sum_nxt;
    e_pay_r <= e_pay_nxt;
  end

  // ---------------- length and unit offset ----------------
  logic                    r_valid;
  logic [31:0]             r_root;
  cpoc_pkg::root_pay_t     r_pay;
  logic                    q_valid;
  logic [2:0][FRAC_BITS:0] q_quo;
  logic [31:0]             q_len;
  cpoc_pkg::back_pay_t     q_pay;

  cpoc_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_v_r),
    .in_rad    (e_sum_r),
    .in_pay    (e_pay_r),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_pay   (r_pay)
  );

  cpoc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_mag    (r_pay.mag),
    .in_len    (r_root),
    .in_pay    (r_pay.back),
    .out_valid (q_valid),
    .out_quo   (q_quo),
    .out_len   (q_len),
    .out_pay   (q_pay)
  );

  // ---------------- stage f: radius, plane and box products ----------------
  logic             f_v_r, f_lz_r;
  logic [2:0][31:0] f_q_r, f_c_r, f_s_r;
  logic [2:0][PMW-1:0] f_pm_r, f_pm_nxt;
  logic [2:0][63:0] f_pp_r, f_pp_nxt;
  logic [2:0][63:0] f_pb_r, f_pb_nxt;

  always_comb begin
    logic signed [FRAC_BITS+1:0] nv;
    logic signed [PMW-1:0]       pm;
    logic signed [63:0]          pp;
    logic signed [63:0]          pb;
    for (int i = 0; i < 3; i++) begin
      nv = q_pay.neg[i] ? -$signed({1'b0, q_quo[i]}) : $signed({1'b0, q_quo[i]});
      pm = nv * $signed({1'b0, radius_r});
      pp = $signed(q_pay.nrm[i]) * $signed(q_pay.plane_dist);
      pb = $signed({1'b0, box_r[i]}) * $signed(q_pay.s[i]);
      f_pm_nxt[i] = pm;
      f_pp_nxt[i] = pp;
      f_pb_nxt[i] = pb;
    end
  end

  // ---------------- stage g: rounding, plane result, box bounds ----------------
  logic             g_v_r, g_lz_r;
  logic [2:0][31:0] g_q_r, g_s_r, g_c_r;
  logic [2:0][31:0] g_m_r, g_m_nxt;
  logic [2:0][31:0] g_pl_r, g_pl_nxt;
  logic [2:0][65:0] g_lo_r, g_lo_nxt, g_hi_r, g_hi_nxt;

  always_comb begin
    logic signed [MRW-1:0] mr;
    logic signed [MRW-1:0] ms;
    logic signed [64:0]    pr;
    logic signed [64:0]    ps;
    logic signed [63:0]    half;
    for (int i = 0; i < 3; i++) begin
      mr = MRW'($signed(f_pm_r[i])) + MRW'(HALF);
      ms = mr >>> FRAC_BITS;
      g_m_nxt[i] = ms[31:0];
      pr = 65'($signed(f_pp_r[i])) + 65'(HALF);
      ps = pr >>> FRAC_BITS;
      g_pl_nxt[i] = cpoc_pkg::sat32(66'($signed(f_q_r[i])) - 66'(ps));
      half = $signed(f_pb_r[i]) >>> (FRAC_BITS + 1);
      g_lo_nxt[i] = 66'($signed(f_c_r[i])) - 66'(half);
      g_hi_nxt[i] = 66'($signed(f_c_r[i])) + 66'(half);
    end
  end

  // ---------------- stage h: scale product, box clamp ----------------
  logic             h_v_r, h_lz_r;
  logic [2:0][31:0] h_q_r, h_c_r, h_pl_r;
  logic [2:0][63:0] h_tp_r, h_tp_nxt;
  logic [2:0][31:0] h_bx_r, h_bx_nxt;
  logic             box_ok;

  always_comb begin
    logic signed [63:0] tp;
    logic signed [65:0] v;
    box_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      tp = $signed(g_m_r[i]) * $signed(g_s_r[i]);
      h_tp_nxt[i] = tp;
      // Lower bound first, then the upper one wins, as for a negative scale.
      v = 66'($signed(g_q_r[i]));
      if (v < $signed(g_lo_r[i])) begin
        v = $signed(g_lo_r[i]);
      end
      if (v > $signed(g_hi_r[i])) begin
        v = $signed(g_hi_r[i]);
      end
      h_bx_nxt[i] = cpoc_pkg::sat32(v);
      if ($signed(g_lo_r[i]) <= $signed(g_hi_r[i]) &&
          (v < $signed(g_lo_r[i]) || v > $signed(g_hi_r[i]))) begin
        box_ok = 1'b0;
      end
    end
  end

  // ---------------- stage i: sphere result and selection ----------------
  logic             out_valid_r;
  logic [2:0][31:0] out_cl_r, out_cl_nxt;

  always_comb begin
    logic signed [64:0] tr;
    logic signed [64:0] ts;
    logic [31:0]        sp;
    for (int i = 0; i < 3; i++) begin
      tr = 65'($signed(h_tp_r[i])) + 65'(HALF);
      ts = tr >>> FRAC_BITS;
      sp = cpoc_pkg::sat32(66'($signed(h_c_r[i])) + 66'(ts));
      case (kind_r)
        cpoc_pkg::SHAPE_SPHERE: out_cl_nxt[i] = h_lz_r ? h_c_r[i] : sp;
        cpoc_pkg::SHAPE_PLANE:  out_cl_nxt[i] = h_pl_r[i];
        cpoc_pkg::SHAPE_BOX:    out_cl_nxt[i] = h_bx_r[i];
        cpoc_pkg::SHAPE_PASS:   out_cl_nxt[i] = h_q_r[i];
        default:                out_cl_nxt[i] = h_q_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r       <= 1'b0;
      g_v_r       <= 1'b0;
      h_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f_v_r       <= q_valid;
      g_v_r       <= f_v_r;
      h_v_r       <= g_v_r;
      out_valid_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f_lz_r   <= (q_len == '0);
    f_q_r    <= q_pay.q;
    f_c_r    <= q_pay.c;
    f_s_r    <= q_pay.s;
    f_pm_r   <= f_pm_nxt;
    f_pp_r   <= f_pp_nxt;
    f_pb_r   <= f_pb_nxt;
    g_lz_r   <= f_lz_r;
    g_q_r    <= f_q_r;
    g_c_r    <= f_c_r;
    g_s_r    <= f_s_r;
    g_m_r    <= g_m_nxt;
    g_pl_r   <= g_pl_nxt;
    g_lo_r   <= g_lo_nxt;
    g_hi_r   <= g_hi_nxt;
    h_lz_r   <= g_lz_r;
    h_q_r    <= g_q_r;
    h_c_r    <= g_c_r;
    h_pl_r   <= g_pl_r;
    h_tp_r   <= h_tp_nxt;
    h_bx_r   <= h_bx_nxt;
    out_cl_r <= out_cl_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_closest_x = out_cl_r[0];
  assign out_closest_y = out_cl_r[1];
  assign out_closest_z = out_cl_r[2];

  // The scaled unit offset can never exceed the radius in magnitude.
  logic m_ok;
  logic sph_chk;
  logic box_chk;

  always_comb begin
    m_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ($signed(g_m_r[i]) > $signed({1'b0, radius_r}) ||
          $signed(g_m_r[i]) < -$signed({1'b0, radius_r})) begin
        m_ok = 1'b0;
      end
    end
  end

  assign sph_chk = g_v_r && !g_lz_r && (kind_r == cpoc_pkg::SHAPE_SPHERE);
  assign box_chk = g_v_r && (kind_r == cpoc_pkg::SHAPE_BOX);

  `CPOC_CHECK_IMPLY(a_radius_bound, clk, rst_n, sph_chk, m_ok, "sphere offset exceeds radius")
  `CPOC_CHECK_IMPLY(a_box_inside, clk, rst_n, box_chk, box_ok, "box clamp left the bounds")
  `CPOC_CHECK_HOLDS(a_busy_reset, clk, rst_n, !busy, "busy raised outside reset")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int FRAC = 16;
  localparam int PIPE_DEPTH = FRAC + 41;

  typedef struct {
    logic signed [31:0] q [3];
    logic signed [31:0] c [3];
    logic signed [31:0] s [3];
    logic signed [17:0] n [3];
  } query_t;

  typedef struct {
    logic signed [31:0] p [3];
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_query_x = '0, in_query_y = '0, in_query_z = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [31:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic signed [17:0] in_plane_normal_x = '0, in_plane_normal_y = '0, in_plane_normal_z = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [31:0] out_closest_x, out_closest_y, out_closest_z;

  closest_point_on_collider DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's registers.
  cpoc_pkg::shape_t shape_mirror = cpoc_pkg::SHAPE_SPHERE;
  longint radius_mirror = 32768;
  longint box_mirror [3] = '{65536, 65536, 65536};

  query_t pending_queries [$];
  point_t expected_points [$];
  query_t on_bus;
  int sender_idle_pct = 8;
  int mismatches = 0;
  int queries_sent = 0;
  int points_checked = 0;
  int kind_count [4] = '{0, 0, 0, 0};

  function automatic longint fix_round(longint x);
    return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic point_t closest_point(query_t t);
    point_t res;
    longint q [3], c [3], s [3], nv [3], d [3], r [3];
    longint unsigned mag [3], mx, sum, len;
    longint dv, nn, m, dot, plane_dist, half, lo, hi;
    int k;
    mx = 0;
    sum = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      q[i] = t.q[i];
      c[i] = t.c[i];
      s[i] = t.s[i];
      nv[i] = t.n[i];
      d[i] = q[i] - c[i];
      r[i] = q[i];
    end
    case (shape_mirror)
      cpoc_pkg::SHAPE_SPHERE: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] = d[i] < 0 ? -d[i] : d[i];
          if (mag[i] > mx) mx = mag[i];
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 31)) k++;
        for (int i = 0; i < 3; i++) begin
          mag[i] >>= k;
          sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          if (len == 0) begin
            r[i] = c[i];
          end else begin
            dv = d[i] < 0 ? -longint'(mag[i]) : longint'(mag[i]);
            nn = (dv <<< FRAC) / longint'(len);
            m = fix_round(nn * radius_mirror);
            r[i] = c[i] + fix_round(m * s[i]);
          end
        end
      end
      cpoc_pkg::SHAPE_PLANE: begin
        for (int i = 0; i < 3; i++) dot += d[i] * nv[i];
        plane_dist = fix_round(dot);
        for (int i = 0; i < 3; i++) r[i] = q[i] - fix_round(nv[i] * plane_dist);
      end
      cpoc_pkg::SHAPE_BOX: begin
        for (int i = 0; i < 3; i++) begin
          half = (box_mirror[i] * s[i]) >>> (FRAC + 1);
          lo = c[i] - half;
          hi = c[i] + half;
          if (r[i] < lo) r[i] = lo;
          if (r[i] > hi) r[i] = hi;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) res.p[i] = clip32(r[i]);
    return res;
  endfunction

  // Driver: one beat per cycle at most, gaps drawn from the current idle rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(closest_point(on_bus));
        kind_count[shape_mirror]++;
        queries_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_queries.size() != 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        on_bus = pending_queries.pop_front();
        in_query_x <= on_bus.q[0];
        in_query_y <= on_bus.q[1];
        in_query_z <= on_bus.q[2];
        in_center_x <= on_bus.c[0];
        in_center_y <= on_bus.c[1];
        in_center_z <= on_bus.c[2];
        in_scale_x <= on_bus.s[0];
        in_scale_y <= on_bus.s[1];
        in_scale_z <= on_bus.s[2];
        in_plane_normal_x <= on_bus.n[0];
        in_plane_normal_y <= on_bus.n[1];
        in_plane_normal_z <= on_bus.n[2];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    point_t want;
    point_t got;
    if (rst_n && out_valid) begin
      got.p[0] = out_closest_x;
      got.p[1] = out_closest_y;
      got.p[2] = out_closest_z;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h %h %h", got.p[0], got.p[1], got.p[2]);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        for (int i = 0; i < 3; i++) begin
          if (got.p[i] !== want.p[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("axis %0d of result %0d: expected %h, got %h",
                       i, points_checked, want.p[i], got.p[i]);
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4: return $urandom_range(262143) - 131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [17:0] pick_normal();
    case ($urandom_range(5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return '0;
      3: return 18'($urandom);
      default: return 18'($urandom_range(131072) - 65536);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t t;
    for (int i = 0; i < 3; i++) begin
      t.q[i] = pick_coord();
      t.c[i] = $urandom_range(1) ? pick_coord() : t.q[i] + $urandom_range(65535) - 32768;
      t.s[i] = $urandom_range(1) ? 32'sd65536 : pick_coord();
      t.n[i] = pick_normal();
    end
    return t;
  endfunction

  function automatic query_t uniform_query(logic signed [31:0] qv, logic signed [31:0] cv,
                                           logic signed [31:0] sv, logic signed [17:0] nv);
    query_t t;
    for (int i = 0; i < 3; i++) begin
      t.q[i] = qv;
      t.c[i] = cv;
      t.s[i] = sv;
      t.n[i] = nv;
    end
    return t;
  endfunction

  task automatic write_reg(cpoc_pkg::cfg_reg_t idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      cpoc_pkg::REG_KIND:   shape_mirror = cpoc_pkg::shape_t'(val[1:0]);
      cpoc_pkg::REG_RADIUS: radius_mirror = longint'(val);
      cpoc_pkg::REG_BOX_X:  box_mirror[0] = longint'(val);
      cpoc_pkg::REG_BOX_Y:  box_mirror[1] = longint'(val);
      default:              box_mirror[2] = longint'(val);
    endcase
  endtask

  task automatic drain();
    while (pending_queries.size() != 0 || start || expected_points.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_size(int phase);
    if (phase < 4) return 31'h7FFF_FFFF;
    if (phase < 8) return '0;
    return $urandom_range(1) ? 31'($urandom_range(1 << 20)) : 31'($urandom);
  endfunction

  initial begin
    query_t t;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset settings (sphere of radius one half).
    pending_queries.push_back(uniform_query(32'sd65536, 32'sd65536, 32'sd65536, 18'sd65536));
    pending_queries.push_back(uniform_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                            18'sd65536));
    pending_queries.push_back(uniform_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                            -18'sd65536));
    pending_queries.push_back(uniform_query(32'sd131072, '0, -32'sd65536, '0));
    pending_queries.push_back(uniform_query('0, '0, '0, 18'h1FFFF));
    pending_queries.push_back(uniform_query(32'sd1, '0, 32'sd65536, 18'h20000));
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      sender_idle_pct = phase < 4 ? 8 : (phase < 8 ? 73 : 0);
      write_reg(cpoc_pkg::REG_KIND, {29'($urandom), 2'(phase % 4)});
      write_reg(cpoc_pkg::REG_RADIUS, phase == 0 ? 31'h7FFF_FFFF : pick_size(phase));
      write_reg(cpoc_pkg::REG_BOX_X, pick_size(phase));
      write_reg(cpoc_pkg::REG_BOX_Y, pick_size(phase));
      write_reg(cpoc_pkg::REG_BOX_Z, pick_size(phase));
      @(posedge clk);
      cfg_we <= 1'b0;
      // Edge beats each phase: extremes and a point on the centre.
      pending_queries.push_back(uniform_query(32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h7FFF_FFFF, 18'sd65536));
      pending_queries.push_back(uniform_query(32'sd4096, 32'sd4096, -32'sd65536, -18'sd65536));
      for (int j = 0; j < 145; j++) begin
        t = random_query();
        pending_queries.push_back(t);
      end
      drain();
    end

    $display("%0d queries checked over 12 register settings", points_checked);
    $display("(sphere %0d, plane %0d, box %0d, pass %0d).",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("%0d of %0d beats sent compared, %0d mismatching fields.",
             points_checked, queries_sent, mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("closest_point_on_collider verification clean");
    end else begin
      $display("closest_point_on_collider verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("closest_point_on_collider verification failed");
    $finish;
  end

endmodule
